[rtl/ssvpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssvpc_pkg
// Shared types and constants of the scheduled solar valve and pump controller.
// ----------------------------------------------------------------------------
package ssvpc_pkg;

    // Commands carried in the input tuser field.
    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_SET_AUTO    = 2'd1;
    localparam logic [1:0] CMD_SET_PUMP    = 2'd2;
    localparam logic [1:0] CMD_SET_SOLAR   = 2'd3;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WIN_START   = 3'd0;
    localparam logic [2:0] REG_WIN_END     = 3'd1;
    localparam logic [2:0] REG_DAY_MASK    = 3'd2;
    localparam logic [2:0] REG_TARGET      = 3'd3;
    localparam logic [2:0] REG_THRESHOLD   = 3'd4;
    localparam logic [2:0] REG_MOVE_TIME   = 3'd5;
    localparam logic [2:0] REG_DISCH_TIME  = 3'd6;

    localparam int MINUTE_W  = 11;
    localparam int TEMP_W    = 12;
    localparam int DUR_W     = 24;
    localparam int MASK_W    = 7;

    // Weekday codes.
    localparam logic [2:0] DAY_SUNDAY      = 3'd0;
    localparam logic [2:0] DAY_SATURDAY    = 3'd6;

    // One decoded input word.
    typedef struct packed {
        logic [1:0]               command;
        logic                     switch_value;
        logic [31:0]              now_ms;
        logic [MINUTE_W-1:0]      minute_of_day;
        logic [2:0]               weekday;
        logic                     clock_valid;
        logic signed [TEMP_W-1:0] water_temp;
        logic signed [TEMP_W-1:0] solar_temp;
    } item_t;

    // One result word.
    typedef struct packed {
        logic auto_in_command;
        logic discharging;
        logic valves_locked;
        logic valves_solar;
        logic pump_on;
    } result_t;

endpackage

[rtl/scheduled_solar_valve_pump_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_solar_valve_pump_control
// Pump and solar valve controller with a weekly auto window and timed coil
// discharge, driven by tick and switch command words.
// ----------------------------------------------------------------------------
// Each input word is taken into an input register, evaluated against the
// controller state in one pass of short logic, and its result word is held
// in an output register. The block accepts one word in every clock cycle
// while the result stream does not hold it back. Each word passes the two
// stages in order, the input register and then the output register, and
// the state update of one word is complete before the next word is
// evaluated. The configuration registers sit on an APB-style port at byte
// address 4*index; the user must write them only while no word is in
// flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module scheduled_solar_valve_pump_control
    import ssvpc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0 up: switch_value[0], now_ms[32:1],
    // minute_of_day[43:33], weekday[46:44], clock_valid[47],
    // water_temp[59:48], solar_temp[71:60].
    input  logic [71:0] s_tdata,
    // tuser fields from bit 0 up: command[1:0].
    input  logic [1:0]  s_tuser,

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata fields from bit 0 up: pump_on[0], valves_solar[1],
    // valves_locked[2], discharging[3], auto_in_command[4], zero[7:5].
    output logic [7:0]  m_tdata,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [MINUTE_W-1:0]      win_start_reg;
    logic [MINUTE_W-1:0]      win_end_reg;
    logic [MASK_W-1:0]        day_mask_reg;
    logic signed [TEMP_W-1:0] target_reg;
    logic signed [TEMP_W-1:0] threshold_reg;
    logic [DUR_W-1:0]         move_time_reg;
    logic [DUR_W-1:0]         disch_time_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg  <= '0;
            win_end_reg    <= '0;
            day_mask_reg   <= '0;
            target_reg     <= 12'sd380;
            threshold_reg  <= 12'sd450;
            move_time_reg  <= 24'd30000;
            disch_time_reg <= 24'd300000;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_WIN_START:  win_start_reg  <= pwdata[MINUTE_W-1:0];
                REG_WIN_END:    win_end_reg    <= pwdata[MINUTE_W-1:0];
                REG_DAY_MASK:   day_mask_reg   <= pwdata[MASK_W-1:0];
                REG_TARGET:     target_reg     <= pwdata[TEMP_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[TEMP_W-1:0];
                REG_MOVE_TIME:  move_time_reg  <= pwdata[DUR_W-1:0];
                REG_DISCH_TIME: disch_time_reg <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the raw register bits, zero extended.
    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_WIN_START:  prdata = {21'd0, win_start_reg};
            REG_WIN_END:    prdata = {21'd0, win_end_reg};
            REG_DAY_MASK:   prdata = {25'd0, day_mask_reg};
            REG_TARGET:     prdata = {20'd0, target_reg};
            REG_THRESHOLD:  prdata = {20'd0, threshold_reg};
            REG_MOVE_TIME:  prdata = {8'd0, move_time_reg};
            REG_DISCH_TIME: prdata = {8'd0, disch_time_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeding the output register.
    // ------------------------------------------------------------------
    logic  in_valid_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    logic  out_free;
    logic  advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.command       <= s_tuser;
            in_item_reg.switch_value  <= s_tdata[0];
            in_item_reg.now_ms        <= s_tdata[32:1];
            in_item_reg.minute_of_day <= s_tdata[43:33];
            in_item_reg.weekday       <= s_tdata[46:44];
            in_item_reg.clock_valid   <= s_tdata[47];
            in_item_reg.water_temp    <= s_tdata[59:48];
            in_item_reg.solar_temp    <= s_tdata[71:60];
        end
    end

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    logic                  auto_en_reg,   auto_en_next;
    logic                  man_pump_reg,  man_pump_next;
    logic                  force_reg,     force_next;
    logic                  valve_reg,     valve_next;
    logic                  lock_reg,      lock_next;
    logic [TIME_WIDTH-1:0] lock_dl_reg,   lock_dl_next;
    logic                  disch_reg,     disch_next;
    logic [TIME_WIDTH-1:0] disch_dl_reg,  disch_dl_next;
    logic                  pump_reg,      pump_next;

    // ------------------------------------------------------------------
    // Schedule window.
    // ------------------------------------------------------------------
    logic       window_active;
    logic       early;
    logic [2:0] prev_day;
    logic [2:0] check_day;
    logic [7:0] mask_ext;
    logic       day_ok;

    assign mask_ext  = {1'b0, day_mask_reg};
    assign early     = in_item_reg.minute_of_day < win_end_reg;
    assign prev_day  = (in_item_reg.weekday == DAY_SUNDAY) ? DAY_SATURDAY
                                                           : in_item_reg.weekday - 3'd1;

    always_comb begin
        window_active = 1'b0;
        check_day     = in_item_reg.weekday;
        if (win_start_reg > win_end_reg && early) begin
            check_day = prev_day;
        end
        day_ok = mask_ext[check_day];
        if (in_item_reg.clock_valid && in_item_reg.weekday <= DAY_SATURDAY) begin
            if (win_start_reg <= win_end_reg) begin
                window_active = day_ok
                             && in_item_reg.minute_of_day >= win_start_reg
                             && in_item_reg.minute_of_day < win_end_reg;
            end else begin
                // The window wraps past midnight: the early part belongs to
                // the day before.
                window_active = day_ok
                             && (early || in_item_reg.minute_of_day >= win_start_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-word evaluation.
    // ------------------------------------------------------------------
    logic [TIME_WIDTH-1:0] now_w;
    logic [TIME_WIDTH-1:0] lock_dl_new;
    logic [TIME_WIDTH-1:0] disch_dl_new;
    logic                  auto_now;
    logic                  lock_kept;
    logic                  do_drive;
    logic                  want_solar;
    result_t               result;

    assign now_w        = TIME_WIDTH'(in_item_reg.now_ms);
    assign lock_dl_new  = now_w + TIME_WIDTH'(move_time_reg);
    assign disch_dl_new = now_w + TIME_WIDTH'(disch_time_reg);
    assign auto_now     = auto_en_reg && window_active;

    always_comb begin
        auto_en_next  = auto_en_reg;
        man_pump_next = man_pump_reg;
        force_next    = force_reg;
        pump_next     = pump_reg;
        disch_next    = disch_reg;
        disch_dl_next = disch_dl_reg;
        lock_kept     = lock_reg;
        do_drive      = 1'b0;
        want_solar    = 1'b0;

        unique case (in_item_reg.command)
            CMD_TICK: begin
                // The lock is released only once its deadline has passed.
                lock_kept = lock_reg && !(now_w > lock_dl_reg);
                pump_next = man_pump_reg || auto_now;
                if (!lock_kept) begin
                    if (auto_now) begin
                        priority if (in_item_reg.water_temp >= target_reg) begin
                            disch_next = 1'b0;
                            do_drive   = 1'b1;
                        end else if (disch_reg) begin
                            // A running discharge holds the valves until it ends.
                            if (now_w >= disch_dl_reg) begin
                                disch_next = 1'b0;
                                do_drive   = 1'b1;
                            end
                        end else if (in_item_reg.solar_temp > threshold_reg) begin
                            disch_next    = 1'b1;
                            disch_dl_next = disch_dl_new;
                            do_drive      = 1'b1;
                            want_solar    = 1'b1;
                        end else begin
                            do_drive = 1'b1;
                        end
                    end else begin
                        do_drive   = 1'b1;
                        want_solar = force_reg;
                    end
                end
            end
            CMD_SET_AUTO: begin
                auto_en_next = in_item_reg.switch_value;
            end
            CMD_SET_PUMP: begin
                man_pump_next = in_item_reg.switch_value;
            end
            CMD_SET_SOLAR: begin
                // The selector takes effect at once, lock or no lock, unless
                // auto is in command.
                force_next = in_item_reg.switch_value;
                if (!auto_now) begin
                    do_drive   = 1'b1;
                    want_solar = in_item_reg.switch_value;
                end
            end
            default: ;
        endcase

        valve_next   = valve_reg;
        lock_next    = lock_kept;
        lock_dl_next = lock_dl_reg;
        if (do_drive) begin
            valve_next = want_solar;
            if (want_solar != valve_reg) begin
                lock_next    = 1'b1;
                lock_dl_next = lock_dl_new;
            end
        end

        result.pump_on         = pump_next;
        result.valves_solar    = valve_next;
        result.valves_locked   = lock_next;
        result.discharging     = disch_next;
        result.auto_in_command = auto_en_next && window_active;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_en_reg  <= 1'b0;
            man_pump_reg <= 1'b0;
            force_reg    <= 1'b0;
            valve_reg    <= 1'b0;
            lock_reg     <= 1'b0;
            lock_dl_reg  <= '0;
            disch_reg    <= 1'b0;
            disch_dl_reg <= '0;
            pump_reg     <= 1'b0;
        end else if (advance) begin
            auto_en_reg  <= auto_en_next;
            man_pump_reg <= man_pump_next;
            force_reg    <= force_next;
            valve_reg    <= valve_next;
            lock_reg     <= lock_next;
            lock_dl_reg  <= lock_dl_next;
            disch_reg    <= disch_next;
            disch_dl_reg <= disch_dl_next;
            pump_reg     <= pump_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    result_t out_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_word_reg};

endmodule
